// ===== sv/srgb_to_cielab_pixel_core_defines.svh =====
// ----------------------------------------------------------------------------
// srgb_to_cielab_pixel_core_defines.svh
// Assertion macros for the sRGB to CIELAB pixel core.
// ----------------------------------------------------------------------------
`ifndef SRGB_TO_CIELAB_PIXEL_CORE_DEFINES_SVH
`define SRGB_TO_CIELAB_PIXEL_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLAB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clab: implication check failed");

// Next-cycle implication, disabled during reset.
`define CLAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clab: next-cycle check failed");

`endif

// ===== sv/clab_pkg.sv =====
// ----------------------------------------------------------------------------
// clab_pkg
// Shared constants, types and the gamma table for the sRGB to CIELAB core.
// ----------------------------------------------------------------------------
package clab_pkg;

  localparam int FRAC_BITS = 8;

  // Q24 linear / XYZ values, up to slightly above 1.0
  localparam int LIN_W  = 25;
  localparam int Q_W    = 25;
  localparam int F_W    = 21;          // Q20 f(t)
  localparam int COEF_W = 14;
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int N_W    = 41;          // scaled dividend
  localparam int K_DIV  = 58;          // reciprocal shift
  localparam int HALF_W = 21;          // partial product split
  localparam int PP_W   = 2 * HALF_W;
  localparam int SUM_W  = 2 * PP_W;

  typedef logic [2:0][Q_W-1:0] xyz_t;
  typedef logic [F_W-1:0]      f_t;
  typedef logic [255:0][LIN_W-1:0] lin_tab_t;

  // sRGB to XYZ matrix, units of 1e-4
  localparam int unsigned MAT_COEF [3][3] = '{
    '{4124, 3576, 1805},
    '{2126, 7152,  722},
    '{ 193, 1192, 9505}
  };

  // every row is scaled by 10 so all reciprocals fit in 42 bits;
  // X and Z divide by the white point, Y's /10000 becomes /100000
  localparam int unsigned DIV_SCALE [3] = '{10, 10, 10};
  localparam int unsigned DIV_OFS   [3] = '{47523, 50000, 54441};
  localparam logic [63:0] DIVISOR   [3] = '{64'd95047, 64'd100000, 64'd108883};
  localparam logic [63:0] DIV_M     [3] = '{
    ((64'd1 << K_DIV) + DIVISOR[0] - 64'd1) / DIVISOR[0],
    ((64'd1 << K_DIV) + DIVISOR[1] - 64'd1) / DIVISOR[1],
    ((64'd1 << K_DIV) + DIVISOR[2] - 64'd1) / DIVISOR[2]
  };

  // f(t) linear segment
  localparam logic [63:0] LIN_T_MAX  = (64'd8856 << 24) / 64'd1000000;
  localparam int unsigned LIN_F_MUL  = 7787;
  localparam int unsigned LIN_F_RND  = 8000;
  localparam logic [63:0] LIN_DIV_M  = ((64'd1 << 31) + 64'd124) / 64'd125;
  localparam logic [63:0] LIN_F_OFS  = ((64'd16 << 20) + 64'd58) / 64'd116;

  // Output rounding
  localparam int SH       = 20 - FRAC_BITS;
  localparam int RND_HALF = 1 << (SH - 1);

  function automatic logic [63:0] pow5_q30(logic [63:0] y);
    logic [63:0] p;
    p = y;
    for (int i = 0; i < 4; i++) begin
      p = (p * y) >> 30;
    end
    return p;
  endfunction

  function automatic logic [63:0] lin_q24(logic [63:0] c);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] lin30;
    if (c * 64'd100000 <= 64'd1031475) begin
      return (c * 64'd100 * (64'd1 << 24) + 64'd164730) / 64'd329460;
    end
    t  = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    u  = (t * t + (64'd1 << 29)) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    for (int k = 0; k < 32; k++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_q30(mid) <= u) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    lin30 = (u * lo) >> 30;
    return (lin30 + 64'd32) >> 6;
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int c = 0; c < 256; c++) begin
      tab[c] = LIN_W'(lin_q24(64'(c)));
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

// ===== sv/clab_xyz.sv =====
// ----------------------------------------------------------------------------
// clab_xyz
// Gamma table, matrix to XYZ and white point scaling, five stages.
// ----------------------------------------------------------------------------
module clab_xyz (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               vld_o,
  output clab_pkg::xyz_t     xyz_o
);

  logic [4:0] vld_q;
  logic [2:0][7:0] pix;
  logic [clab_pkg::LIN_W-1:0]  lin_q  [3];
  logic [clab_pkg::PROD_W-1:0] prod_q [3][3];
  logic [clab_pkg::N_W-1:0]    n_q    [3];
  logic [clab_pkg::PP_W-1:0]   pp_q   [3][4];
  logic [clab_pkg::Q_W-1:0]    quo    [3];

  assign pix = {blue_i, green_i, red_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  assign vld_o = vld_q[4];

  for (genvar j = 0; j < 3; j++) begin : g_ch
    always_ff @(posedge clk_i) begin
      lin_q[j] <= clab_pkg::LIN_TAB[pix[j]];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    logic [clab_pkg::N_W-1:0]    sum;
    logic [clab_pkg::N_W-1:0]    n_d;
    logic [63:0]                 m;
    logic [clab_pkg::SUM_W-1:0]  full;

    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        prod_q[i][j] <= clab_pkg::PROD_W'(lin_q[j])
                      * clab_pkg::PROD_W'(clab_pkg::MAT_COEF[i][j]);
      end
    end

    assign sum = clab_pkg::N_W'(prod_q[i][0]) + clab_pkg::N_W'(prod_q[i][1])
               + clab_pkg::N_W'(prod_q[i][2]);
    assign n_d = clab_pkg::N_W'(sum * clab_pkg::N_W'(clab_pkg::DIV_SCALE[i]))
               + clab_pkg::N_W'(clab_pkg::DIV_OFS[i]);
    assign m   = clab_pkg::DIV_M[i];

    // reciprocal multiply, split in 21-bit halves
    always_ff @(posedge clk_i) begin
      n_q[i]     <= n_d;
      pp_q[i][0] <= clab_pkg::PP_W'(n_q[i][40:21]) * clab_pkg::PP_W'(m[41:21]);
      pp_q[i][1] <= clab_pkg::PP_W'(n_q[i][40:21]) * clab_pkg::PP_W'(m[20:0]);
      pp_q[i][2] <= clab_pkg::PP_W'(n_q[i][20:0])  * clab_pkg::PP_W'(m[41:21]);
      pp_q[i][3] <= clab_pkg::PP_W'(n_q[i][20:0])  * clab_pkg::PP_W'(m[20:0]);
    end

    assign full = (clab_pkg::SUM_W'(pp_q[i][0]) << (2 * clab_pkg::HALF_W))
                + ((clab_pkg::SUM_W'(pp_q[i][1]) + clab_pkg::SUM_W'(pp_q[i][2]))
                   << clab_pkg::HALF_W)
                + clab_pkg::SUM_W'(pp_q[i][3]);

    assign quo[i] = full[clab_pkg::K_DIV +: clab_pkg::Q_W];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      xyz_o[i] <= quo[i];
    end
  end

endmodule

// ===== sv/clab_f.sv =====
// ----------------------------------------------------------------------------
// clab_f
// CIELAB f(t): 21-stage bitwise cube root, linear segment alongside.
// ----------------------------------------------------------------------------
module clab_f (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  logic [clab_pkg::Q_W-1:0] t_i,
  output logic                     vld_o,
  output clab_pkg::f_t             f_o
);

  localparam int STEPS = clab_pkg::F_W;
  localparam int REM_W = clab_pkg::Q_W + 36;
  localparam int Y2_W  = clab_pkg::F_W + 1;
  localparam int SQ_W  = 2 * Y2_W;
  localparam int B_W   = SQ_W + 2;
  localparam int AUX_W = 31;

  logic                     vld_q  [STEPS];
  logic                     lin_q  [STEPS];
  logic [REM_W-1:0]         rem_q  [STEPS];
  logic [clab_pkg::F_W-1:0] root_q [STEPS];
  logic [AUX_W-1:0]         aux_q  [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stg
    localparam int S = REM_W - 1 - 3 * i;
    logic                     vld_in;
    logic                     lin_in;
    logic [REM_W-1:0]         rem_in;
    logic [REM_W-1:0]         rem_d;
    logic [clab_pkg::F_W-1:0] root_in;
    logic [clab_pkg::F_W-1:0] root_d;
    logic [AUX_W-1:0]         aux_in;
    logic [AUX_W-1:0]         aux_d;
    logic [Y2_W-1:0]          y2;
    logic [SQ_W-1:0]          sq;
    logic [B_W-1:0]           b;
    logic                     ge;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = {t_i, 36'd0};
      assign root_in = '0;
      assign lin_in  = (t_i <= clab_pkg::Q_W'(clab_pkg::LIN_T_MAX));
      assign aux_in  = AUX_W'(clab_pkg::LIN_F_MUL * 32'(t_i[17:0]))
                     + AUX_W'(clab_pkg::LIN_F_RND);
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign lin_in  = lin_q[i-1];
      assign aux_in  = aux_q[i-1];
    end

    // trial value 3y(y+1)+1 for the next root bit
    assign y2     = {1'b0, root_in[clab_pkg::F_W-2:0], 1'b0};
    assign sq     = SQ_W'(y2) * (SQ_W'(y2) + SQ_W'(1));
    assign b      = B_W'({sq, 1'b0}) + B_W'(sq) + B_W'(1);
    assign ge     = (rem_in >> S) >= REM_W'(b);
    assign rem_d  = ge ? rem_in - (REM_W'(b) << S) : rem_in;
    assign root_d = {root_in[clab_pkg::F_W-2:0], ge};

    // linear segment: divide by 16000 as >>7 then reciprocal of 125
    if (i == 1) begin : g_lin_div
      logic [48:0] lq;
      assign lq    = 49'(aux_in[30:7]) * 49'(clab_pkg::LIN_DIV_M);
      assign aux_d = AUX_W'(lq[48:31]) + AUX_W'(clab_pkg::LIN_F_OFS);
    end else begin : g_lin_pass
      assign aux_d = aux_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      lin_q[i]  <= lin_in;
      rem_q[i]  <= rem_d;
      root_q[i] <= root_d;
      aux_q[i]  <= aux_d;
    end
  end

  assign vld_o = vld_q[STEPS-1];
  assign f_o   = lin_q[STEPS-1] ? aux_q[STEPS-1][clab_pkg::F_W-1:0] : root_q[STEPS-1];

endmodule

// ===== sv/clab_out.sv =====
// ----------------------------------------------------------------------------
// clab_out
// L, a, b from f values; rounding and saturation, two stages.
// ----------------------------------------------------------------------------
module clab_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  clab_pkg::f_t        fx_i,
  input  clab_pkg::f_t        fy_i,
  input  clab_pkg::f_t        fz_i,
  output logic                done_o,
  output logic [14:0]         lightness_o,
  output logic signed [15:0]  green_red_axis_o,
  output logic signed [15:0]  blue_yellow_axis_o
);

  localparam int V_W = 34;

  logic vld_q;
  logic signed [V_W-1:0] fxs, fys, fzs;
  logic signed [V_W-1:0] lv_q, av_q, bv_q;
  logic signed [V_W-1:0] lr, ar, br;

  function automatic logic signed [V_W-1:0] round_sh(logic signed [V_W-1:0] v);
    logic signed [V_W-1:0] t;
    // halves away from zero
    t = v + signed'(V_W'(clab_pkg::RND_HALF)) - signed'(V_W'(v[V_W-1]));
    return t >>> clab_pkg::SH;
  endfunction

  assign fxs = signed'(V_W'(fx_i));
  assign fys = signed'(V_W'(fy_i));
  assign fzs = signed'(V_W'(fz_i));

  always_ff @(posedge clk_i) begin
    lv_q <= fys * 34'sd116 - 34'sd16777216;
    av_q <= (fxs - fys) * 34'sd500;
    bv_q <= (fys - fzs) * 34'sd200;
  end

  assign lr = round_sh(lv_q);
  assign ar = round_sh(av_q);
  assign br = round_sh(bv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= vld_i;
      done_o <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lr < 34'sd0) begin
      lightness_o <= 15'd0;
    end else if (lr > 34'sd32767) begin
      lightness_o <= 15'h7fff;
    end else begin
      lightness_o <= lr[14:0];
    end
    if (ar < -34'sd32768) begin
      green_red_axis_o <= 16'sh8000;
    end else if (ar > 34'sd32767) begin
      green_red_axis_o <= 16'sh7fff;
    end else begin
      green_red_axis_o <= ar[15:0];
    end
    if (br < -34'sd32768) begin
      blue_yellow_axis_o <= 16'sh8000;
    end else if (br > 34'sd32767) begin
      blue_yellow_axis_o <= 16'sh7fff;
    end else begin
      blue_yellow_axis_o <= br[15:0];
    end
  end

endmodule

// ===== sv/srgb_to_cielab_pixel_core.sv =====
// ----------------------------------------------------------------------------
// srgb_to_cielab_pixel_core
// 8-bit sRGB pixel to CIELAB (D65), fixed point (L unsigned, a and b signed), fully pipelined.
// ----------------------------------------------------------------------------
// channel  | ports                                  | handshake
// ---------+----------------------------------------+-----------------------
// pixel in | red_i, green_i, blue_i                 | start_i & !busy_o
// Lab out  | lightness_o, green_red_axis_o,          | done_o, one cycle,
//          | blue_yellow_axis_o                      | no backpressure
//
// One pixel beat per clock. Pipeline: 5 stages gamma/matrix/white divide, 21
// cube root stages (one root bit per stage), 2 stages for L/a/b and saturation.
// busy_o stays low: nothing downstream can stall, so the pipe just flows.
// Reset clears only the valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "srgb_to_cielab_pixel_core_defines.svh"

module srgb_to_cielab_pixel_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               done_o,
  output logic [14:0]        lightness_o,
  output logic signed [15:0] green_red_axis_o,
  output logic signed [15:0] blue_yellow_axis_o
);

  localparam int LAT = 28;

  logic               xyz_vld;
  clab_pkg::xyz_t     xyz;
  logic [2:0]         f_vld;
  clab_pkg::f_t       f_val [3];
  logic               black_in;

  // never stalls
  assign busy_o = 1'b0;

  // gamma table, matrix, white point scaling
  clab_xyz u_xyz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .vld_o   (xyz_vld),
    .xyz_o   (xyz)
  );

  // one f(t) pipe per axis
  for (genvar i = 0; i < 3; i++) begin : g_f
    clab_f u_f (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (xyz_vld),
      .t_i    (xyz[i]),
      .vld_o  (f_vld[i]),
      .f_o    (f_val[i])
    );
  end

  // L, a, b and saturation
  clab_out u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .vld_i              (f_vld[1]),
    .fx_i               (f_val[0]),
    .fy_i               (f_val[1]),
    .fz_i               (f_val[2]),
    .done_o             (done_o),
    .lightness_o        (lightness_o),
    .green_red_axis_o   (green_red_axis_o),
    .blue_yellow_axis_o (blue_yellow_axis_o)
  );

  // black pixel beat accepted this cycle
  assign black_in = start_i && !busy_o && ({red_i, green_i, blue_i} == 24'd0);

  // the three f pipes run in lock step
  `CLAB_ASSERT_IMPL(a_lanes_aligned, f_vld[1], f_vld[0] && f_vld[2])
  // output follows f by two stages
  `CLAB_ASSERT_NEXT(a_out_after_f, $past(f_vld[1]), done_o)
  // a black pixel comes out as L = a = b = 0
  `CLAB_ASSERT_IMPL(a_black_is_zero, done_o && $past(black_in, LAT), {lightness_o, green_red_axis_o, blue_yellow_axis_o} == 47'd0)

endmodule

// ===== tb/tb_srgb_to_cielab_pixel_core.sv =====
// ----------------------------------------------------------------------------
// tb_srgb_to_cielab_pixel_core
// Drives sRGB pixels into the CIELAB core and checks each Lab beat against a
// behavioral predictor (gamma curve, D65 matrix, cube-root law) or a typed
// zero beat (black). A short directed list runs first, then random pixels.
// ----------------------------------------------------------------------------
module tb_srgb_to_cielab_pixel_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = clab_pkg::FRAC_BITS;
  localparam int N_RANDOM = 1950;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [14:0] light;
    logic [15:0] ga;
    logic [15:0] by;
  } lab_beat_t;

  // Directed row: pixel, plus an optional typed expectation
  typedef struct {
    logic [7:0] r, g, b;
    bit         fixed;
    lab_beat_t  lab;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [7:0] red_i = '0, green_i = '0, blue_i = '0;
  logic busy_o, done_o;
  logic [14:0] lightness_o;
  logic signed [15:0] green_red_axis_o, blue_yellow_axis_o;

  lab_beat_t pending_lab[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit allow_gaps = 1'b1;
  logic [63:0] gamma_lut [256];

  srgb_to_cielab_pixel_core u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .red_i, .green_i, .blue_i,
    .done_o, .lightness_o, .green_red_axis_o, .blue_yellow_axis_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---- predictor ----------------------------------------------------------
  // fifth power in Q30 by four truncating multiplies
  function automatic logic [63:0] fifth_q30(logic [63:0] v);
    logic [63:0] p;
    p = v;
    repeat (4) p = (p * v) >> 30;
    return p;
  endfunction

  // sRGB decode to linear Q24: linear toe, else x^2.4 = (x^2)^(1/5)*x^2
  function automatic logic [63:0] decode_gamma(logic [63:0] c);
    logic [63:0] t, sq, lo, hi, mid;
    if (c * 100000 <= 1031475) return (c * 100 * (64'd1 << 24) + 164730) / 329460;
    t  = (((1000 * c + 14025) << 30) + 134512) / 269025;
    sq = (t * t + (64'd1 << 29)) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (fifth_q30(mid) <= sq) lo = mid;
      else hi = mid - 1;
    end
    return (((sq * lo) >> 30) + 32) >> 6;
  endfunction

  // Lab companding: cube root above the knee, linear segment below, Q20
  function automatic longint lab_compand(logic [63:0] t24);
    logic [63:0] n, lo, hi, mid;
    if (t24 * 1000000 > (64'd8856 << 24)) begin
      n  = t24 << 36;
      lo = 0;
      hi = 64'd1 << 21;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (mid * mid * mid <= n) lo = mid;
        else hi = mid - 1;
      end
      return longint'(lo);
    end
    return longint'((7787 * t24 + 8000) / 16000) + longint'(((64'd16 << 20) + 58) / 116);
  endfunction

  // Q20 to output format, halves away from zero, then saturate
  function automatic longint round_sat(longint v, longint lo, longint hi);
    longint half, q;
    half = longint'(1) << (19 - FRAC);
    if (v >= 0) q = (v + half) >>> (20 - FRAC);
    else q = -((-v + half) >>> (20 - FRAC));
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q;
  endfunction

  function automatic lab_beat_t predict_lab(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    logic [63:0] r, g, b, sx, sy, sz;
    longint fx, fy, fz;
    lab_beat_t o;
    r  = gamma_lut[r8];
    g  = gamma_lut[g8];
    b  = gamma_lut[b8];
    sx = r * 4124 + g * 3576 + b * 1805;
    sy = r * 2126 + g * 7152 + b * 722;
    sz = r * 193 + g * 1192 + b * 9505;
    fx = lab_compand((sx * 10 + 47523) / 95047);
    fy = lab_compand((sy + 5000) / 10000);
    fz = lab_compand((sz * 10 + 54441) / 108883);
    o.light = 15'(round_sat(116 * fy - (longint'(16) << 20), 0, 32767));
    o.ga    = 16'(round_sat(500 * (fx - fy), -32768, 32767));
    o.by    = 16'(round_sat(200 * (fy - fz), -32768, 32767));
    return o;
  endfunction

  // ---- driver -------------------------------------------------------------
  // Presents one pixel at the falling edge and holds it until accepted.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            bit fixed, lab_beat_t lab);
    lab_beat_t want;
    want = fixed ? lab : predict_lab(r, g, b);
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    do @(posedge clk_i); while (busy_o);
    pending_lab.insert(pending_lab.size(), want);
    n_sent++;
    @(negedge clk_i);
  endtask

  // ---- monitor / scoreboard -----------------------------------------------
  always @(posedge clk_i) begin
    lab_beat_t w;
    if (rst_ni && done_o) begin
      n_checked++;
      if (pending_lab.size() == 0) begin
        errors++;
        $display("%0t: Lab beat with nothing expected (L=%0h a=%0h b=%0h)", $time,
                 lightness_o, green_red_axis_o, blue_yellow_axis_o);
      end else begin
        w = pending_lab.pop_front();
        if (lightness_o !== w.light) begin
          errors++;
          $display("%0t: L mismatch exp %0h got %0h", $time, w.light, lightness_o);
        end
        if (green_red_axis_o !== w.ga) begin
          errors++;
          $display("%0t: a mismatch exp %0h got %0h", $time, w.ga, green_red_axis_o);
        end
        if (blue_yellow_axis_o !== w.by) begin
          errors++;
          $display("%0t: b mismatch exp %0h got %0h", $time, w.by, blue_yellow_axis_o);
        end
      end
    end
  end

  // Watchdog: cycles with neither an input beat nor a result beat
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d beats outstanding", $time, pending_lab.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---- stimulus -----------------------------------------------------------
  initial begin
    pixel_row_t rows[$];
    pixel_row_t row;
    lab_beat_t none;
    int drain;
    none = '{15'd0, 16'd0, 16'd0};
    for (int c = 0; c < 256; c++) gamma_lut[c] = decode_gamma(64'(c));

    // black is L=0 a=0 b=0; white is L=100 a~0 b~0 (checked by predictor)
    rows.insert(rows.size(), '{8'd0, 8'd0, 8'd0, 1'b1, none});
    rows.insert(rows.size(), '{8'd255, 8'd255, 8'd255, 1'b0, none});
    rows.insert(rows.size(), '{8'd255, 8'd0, 8'd0, 1'b0, none});
    rows.insert(rows.size(), '{8'd0, 8'd255, 8'd0, 1'b0, none});
    rows.insert(rows.size(), '{8'd0, 8'd0, 8'd255, 1'b0, none});
    rows.insert(rows.size(), '{8'd255, 8'd0, 8'd255, 1'b0, none});
    rows.insert(rows.size(), '{8'd255, 8'd255, 8'd0, 1'b0, none});
    rows.insert(rows.size(), '{8'd0, 8'd255, 8'd255, 1'b0, none});
    // gamma toe boundary: 10 is linear, 11 on the curve
    rows.insert(rows.size(), '{8'd10, 8'd10, 8'd10, 1'b0, none});
    rows.insert(rows.size(), '{8'd11, 8'd11, 8'd11, 1'b0, none});
    // greys 1 and 20 sit below the cube-root knee; 24 and 128 lie above it
    rows.insert(rows.size(), '{8'd1, 8'd1, 8'd1, 1'b0, none});
    rows.insert(rows.size(), '{8'd20, 8'd20, 8'd20, 1'b0, none});
    rows.insert(rows.size(), '{8'd24, 8'd24, 8'd24, 1'b0, none});
    rows.insert(rows.size(), '{8'd128, 8'd128, 8'd128, 1'b0, none});
    rows.insert(rows.size(), '{8'd170, 8'd85, 8'd1, 1'b0, none});
    rows.insert(rows.size(), '{8'd85, 8'd170, 8'd254, 1'b0, none});
    rows.insert(rows.size(), '{8'd1, 8'd0, 8'd0, 1'b0, none});
    rows.insert(rows.size(), '{8'd0, 8'd0, 8'd1, 1'b0, none});

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].fixed, rows[i].lab);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 300) allow_gaps = 1'b0;   // back-to-back tail
      case ($urandom_range(0, 3))
        0: begin   // greys walk the whole gamma table
          row.r = 8'($urandom_range(0, 255));
          row.g = row.r;
          row.b = row.r;
        end
        1: begin   // dark corner around the knees
          row.r = 8'($urandom_range(0, 30));
          row.g = 8'($urandom_range(0, 30));
          row.b = 8'($urandom_range(0, 30));
        end
        default: begin
          row.r = 8'($urandom);
          row.g = 8'($urandom);
          row.b = 8'($urandom);
        end
      endcase
      send_pixel(row.r, row.g, row.b, 1'b0, none);
    end
    start_i <= 1'b0;
    stim_done = 1'b1;

    drain = 0;
    while (pending_lab.size() != 0 && drain < 200) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (40) @(posedge clk_i);   // catch any stray beat past the pipe depth
    if (pending_lab.size() != 0) begin
      errors++;
      $display("%0t: %0d Lab beats never arrived", $time, pending_lab.size());
    end

    $display("Converted %0d pixels (greys, primaries, toe and knee regions, random RGB);",
             n_sent);
    $display("%0d Lab beats compared, %0d field mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/clab_pkg.sv
sv/clab_xyz.sv
sv/clab_f.sv
sv/clab_out.sv
sv/srgb_to_cielab_pixel_core.sv
tb/tb_srgb_to_cielab_pixel_core.sv
